// ===== rtl/pcxrle_pkg.sv =====
package pcxrle_pkg;

    // Default depth of the line store, in bytes per plane.
    localparam int DEF_MAX_PLANE_BYTES = 1024;

    // A byte at or above this value opens a run; the excess is the repeat count.
    localparam logic [7:0] RUN_MARK = 8'd192;

    // Register widths and their values after reset.
    localparam int PLANE_BYTES_W  = 11;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int COLUMN_W       = 10;

    localparam logic [PLANE_BYTES_W-1:0]  RST_PLANE_BYTES  = 11'd1024;
    localparam logic [IMAGE_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [IMAGE_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd65535;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PLANE_BYTES  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_index;

    // Colour plane codes in the order they arrive within a scan line.
    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;    // accept the input transaction
        logic place;      // place the current byte once
        logic capture;    // load the line store read data into the hold stage
        logic push;       // move the hold stage into the output register
        logic push_last;  // the pushed pixel ends the burst
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_work;  // the offered byte is a literal or the data byte of a run
        logic count_zero;  // no placements left for the current byte
        logic produce;     // the next placement makes a pixel
        logic hold_valid;  // a pixel waits in the hold stage
        logic out_free;    // the output register can take a pixel now
    } t_dp_sts;

endpackage

// ===== rtl/pcxrle_ram.sv =====
module pcxrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcxrle_ctrl.sv =====
module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_READ  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state  r_state;
    t_state  n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_in = 1'b1;
                    if (i_sts.start_work) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_sts.count_zero) begin
                    n_state = i_sts.hold_valid ? S_FLUSH : S_IDLE;
                end else if (i_sts.produce && i_sts.hold_valid && !i_sts.out_free) begin
                    // The held pixel has nowhere to go yet.
                    n_state = S_RUN;
                end else begin
                    o_cmd.place = 1'b1;
                    if (i_sts.produce) begin
                        o_cmd.push = i_sts.hold_valid;
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = S_RUN;
            end
            S_FLUSH: begin
                if (!i_sts.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/pcxrle_dp.sv =====
module pcxrle_dp
    import pcxrle_pkg::*;
#(
    parameter int MAX_PLANE_BYTES = DEF_MAX_PLANE_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_start_of_image,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [7:0]                o_blue,
    output logic [7:0]                o_green,
    output logic [7:0]                o_red,
    output logic [COLUMN_W-1:0]       o_column,
    output logic [IMAGE_HEIGHT_W-1:0] o_row,
    output logic                      o_last_of_burst,
    output logic                      o_last_of_image
);

    localparam int AW = $clog2(MAX_PLANE_BYTES);
    // Common width for position compares; wide enough for every operand.
    localparam int CW = AW + 12;

    // Configuration registers.
    logic [PLANE_BYTES_W-1:0]  r_plane_bytes;
    logic [IMAGE_WIDTH_W-1:0]  r_image_width;
    logic [IMAGE_HEIGHT_W-1:0] r_image_height;

    // Decoder position and run state.
    logic                      r_run_pending;
    logic [5:0]                r_run_length;
    logic [1:0]                r_plane_index;
    logic [AW-1:0]             r_byte_offset;
    logic [IMAGE_HEIGHT_W-1:0] r_row_count;
    logic                      r_image_done;
    logic [5:0]                r_count;
    logic [7:0]                r_byte;

    // Hold stage: the newest pixel, kept until it is known whether it ends the burst.
    logic                      r_h_valid;
    logic [7:0]                r_h_blue;
    logic [7:0]                r_h_green;
    logic [7:0]                r_h_red;
    logic [COLUMN_W-1:0]       r_h_col;
    logic [IMAGE_HEIGHT_W-1:0] r_h_row;
    logic                      r_h_loi;

    // Output register.
    logic                      r_o_valid;
    logic [7:0]                r_o_blue;
    logic [7:0]                r_o_green;
    logic [7:0]                r_o_red;
    logic [COLUMN_W-1:0]       r_o_col;
    logic [IMAGE_HEIGHT_W-1:0] r_o_row;
    logic                      r_o_lob;
    logic                      r_o_loi;

    logic [CW-1:0]             pb_raw;
    logic [CW-1:0]             pb_eff;
    logic [CW-1:0]             pb_m1;
    logic [CW-1:0]             off_ext;
    logic [CW-1:0]             idx_ext;
    logic [CW-1:0]             idx_p1;
    logic [CW-1:0]             width_ext;
    logic [CW-1:0]             last_col;
    logic [AW-1:0]             idx;
    logic [IMAGE_HEIGHT_W:0]   height_eff;
    logic [IMAGE_HEIGHT_W:0]   row_p1;
    logic [IMAGE_HEIGHT_W-1:0] row_next;
    logic                      done_next;
    logic                      line_end;
    logic                      produce;
    logic                      loi;
    logic                      eff_pending;
    logic [7:0]                run_len_in;
    logic                      out_take;
    logic                      we_red;
    logic                      we_green;
    logic [7:0]                rd_red;
    logic [7:0]                rd_green;

    // Effective plane size, clamped to 1 .. MAX_PLANE_BYTES.
    always_comb begin
        pb_raw = {{(CW-PLANE_BYTES_W){1'b0}}, r_plane_bytes};
        if (pb_raw == '0) begin
            pb_eff = CW'(1);
        end else if (pb_raw > CW'(MAX_PLANE_BYTES)) begin
            pb_eff = CW'(MAX_PLANE_BYTES);
        end else begin
            pb_eff = pb_raw;
        end
    end

    assign pb_m1     = pb_eff - CW'(1);
    assign off_ext   = {{(CW-AW){1'b0}}, r_byte_offset};
    assign idx_ext   = (off_ext >= pb_eff) ? pb_m1 : off_ext;
    assign idx       = idx_ext[AW-1:0];
    assign idx_p1    = idx_ext + CW'(1);
    assign width_ext = {{(CW-IMAGE_WIDTH_W){1'b0}}, r_image_width};
    assign last_col  = ((width_ext < pb_eff) ? width_ext : pb_eff) - CW'(1);
    assign line_end  = (idx_ext == pb_m1);

    // Row bookkeeping; a height of zero counts as one row.
    assign height_eff = (r_image_height == '0) ? (IMAGE_HEIGHT_W+1)'(1)
                                               : {1'b0, r_image_height};
    assign row_p1     = {1'b0, r_row_count} + (IMAGE_HEIGHT_W+1)'(1);
    assign row_next   = row_p1[IMAGE_HEIGHT_W-1:0];
    assign done_next  = ({1'b0, row_next} >= height_eff) || (row_next == '0);

    // A blue byte inside the visible width makes a pixel.
    assign produce = !r_image_done && (r_plane_index == PLANE_BLUE) && (idx_ext < width_ext);
    assign loi     = (idx_ext == last_col) && (row_p1 == height_eff);

    // Input decode.
    assign eff_pending = r_run_pending && !i_start_of_image;
    assign run_len_in  = i_data_byte - RUN_MARK;

    assign out_take = r_o_valid && !i_stall;

    // Status toward the controller.
    assign o_sts.start_work = eff_pending || (i_data_byte < RUN_MARK);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.produce    = produce;
    assign o_sts.hold_valid = r_h_valid;
    assign o_sts.out_free   = !r_o_valid || !i_stall;

    // Line store: one byte lane for each of the first two planes.
    assign we_red   = i_cmd.place && !r_image_done && (r_plane_index == PLANE_RED);
    assign we_green = i_cmd.place && !r_image_done && (r_plane_index == PLANE_GREEN);

    pcxrle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PLANE_BYTES)
    ) u_ram_red (
        .i_clk   (i_clk),
        .i_we    (we_red),
        .i_waddr (idx),
        .i_wdata (r_byte),
        .i_raddr (idx),
        .o_rdata (rd_red)
    );

    pcxrle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PLANE_BYTES)
    ) u_ram_green (
        .i_clk   (i_clk),
        .i_we    (we_green),
        .i_waddr (idx),
        .i_wdata (r_byte),
        .i_raddr (idx),
        .o_rdata (rd_green)
    );

    // Control state: configuration, position, run state and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_bytes  <= RST_PLANE_BYTES;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_run_pending  <= 1'b0;
            r_run_length   <= '0;
            r_plane_index  <= PLANE_RED;
            r_byte_offset  <= '0;
            r_row_count    <= '0;
            r_image_done   <= 1'b0;
            r_count        <= '0;
            r_h_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PLANE_BYTES:  r_plane_bytes  <= i_cfg_data[PLANE_BYTES_W-1:0];
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Input transaction: restart the image if asked, then decode the byte.
            if (i_cmd.take_in) begin
                if (i_start_of_image) begin
                    r_plane_index <= PLANE_RED;
                    r_byte_offset <= '0;
                    r_row_count   <= '0;
                    r_image_done  <= 1'b0;
                end
                if (eff_pending) begin
                    r_count       <= r_run_length;
                    r_run_pending <= 1'b0;
                    r_run_length  <= '0;
                end else if (i_data_byte >= RUN_MARK) begin
                    r_run_pending <= 1'b1;
                    r_run_length  <= run_len_in[5:0];
                end else begin
                    r_count       <= 6'd1;
                    r_run_pending <= 1'b0;
                    r_run_length  <= '0;
                end
            end

            // One placement: advance column, plane and row.
            if (i_cmd.place) begin
                r_count <= r_count - 6'd1;
                if (!r_image_done) begin
                    if (line_end) begin
                        r_byte_offset <= '0;
                        if (r_plane_index == PLANE_BLUE) begin
                            r_plane_index <= PLANE_RED;
                            r_row_count   <= row_next;
                            if (done_next) begin
                                r_image_done <= 1'b1;
                            end
                        end else begin
                            r_plane_index <= r_plane_index + 2'd1;
                        end
                    end else begin
                        r_byte_offset <= idx_p1[AW-1:0];
                    end
                end
            end

            // Hold stage fills after the line store read and empties on a push.
            if (i_cmd.capture) begin
                r_h_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_h_valid <= 1'b0;
            end

            // Output register handshake.
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in && o_sts.start_work) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.place && produce) begin
            r_h_blue <= r_byte;
            r_h_col  <= idx_ext[COLUMN_W-1:0];
            r_h_row  <= r_row_count;
            r_h_loi  <= loi;
        end
        if (i_cmd.capture) begin
            r_h_green <= rd_green;
            r_h_red   <= rd_red;
        end
        if (i_cmd.push) begin
            r_o_blue  <= r_h_blue;
            r_o_green <= r_h_green;
            r_o_red   <= r_h_red;
            r_o_col   <= r_h_col;
            r_o_row   <= r_h_row;
            r_o_loi   <= r_h_loi;
            r_o_lob   <= i_cmd.push_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_blue          = r_o_blue;
    assign o_green         = r_o_green;
    assign o_red           = r_o_red;
    assign o_column        = r_o_col;
    assign o_row           = r_o_row;
    assign o_last_of_burst = r_o_lob;
    assign o_last_of_image = r_o_loi;

endmodule

// ===== rtl/pcx_rle_planar_decoder.sv =====
// Run-length decoder for 24-bit, three-plane PCX image data, fed one byte per
// transaction starting after the file header. Bytes of 192 and above announce a
// run of the following byte; all other bytes are literals. Decoded bytes fill
// red, green and blue planes of plane_bytes each; red and green are kept in two
// byte-wide line store RAMs, and each blue byte inside the visible width emits
// one pixel with its column and row. last_of_burst marks the final pixel that
// one input byte produces, last_of_image the bottom-right pixel. Bytes that
// follow the last row are dropped until start_of_image. Configuration must be
// written only while the decoder is idle; the decoder itself does not enforce
// this. A run marker is taken without a stall. Any other byte holds the input
// stalled until its placements are done: they go through the controller one
// at a time, dropped bytes included, each pixel adds a registered line store
// read, and the last pixel must leave the hold stage. A full output register
// stalls a burst when a second pixel is ready behind the held one, and it
// delays the hand-off of the last pixel, which the next byte waits for.
module pcx_rle_planar_decoder
    import pcxrle_pkg::*;
#(
    parameter int MAX_PLANE_BYTES = DEF_MAX_PLANE_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_start_of_image,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_blue,
    output logic [7:0]                o_green,
    output logic [7:0]                o_red,
    output logic [COLUMN_W-1:0]       o_column,
    output logic [IMAGE_HEIGHT_W-1:0] o_row,
    output logic                      o_last_of_burst,
    output logic                      o_last_of_image
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer for input decode, placements and pixel hand-off.
    pcxrle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Position counters, line store and output registers.
    pcxrle_dp #(
        .MAX_PLANE_BYTES (MAX_PLANE_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_blue           (o_blue),
        .o_green          (o_green),
        .o_red            (o_red),
        .o_column         (o_column),
        .o_row            (o_row),
        .o_last_of_burst  (o_last_of_burst),
        .o_last_of_image  (o_last_of_image)
    );

endmodule

// ===== tb/sv/pcx_rle_planar_decoder_chk.sv =====
`timescale 1ns / 100ps

module pcx_rle_planar_decoder_chk
    import pcxrle_pkg::*;
#(
    parameter int MAX_PLANE_BYTES = DEF_MAX_PLANE_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel of the decoder.
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_start_of_image,
    // Register write port.
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Pixel channel of the decoder.
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [7:0]                i_blue,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_red,
    input  logic [COLUMN_W-1:0]       i_column,
    input  logic [IMAGE_HEIGHT_W-1:0] i_row,
    input  logic                      i_last_of_burst,
    input  logic                      i_last_of_image,
    // Status handed to the stimulus side.
    output int                        o_error_count,
    output int                        o_pending,
    output int                        o_pixel_count,
    output logic                      o_image_done
);

    typedef struct packed {
        logic [7:0]                blue;
        logic [7:0]                green;
        logic [7:0]                red;
        logic [COLUMN_W-1:0]       column;
        logic [IMAGE_HEIGHT_W-1:0] row;
        logic                      last_of_burst;
        logic                      last_of_image;
    } pixel_t;

    // Pixels predicted but not yet seen on the output channel.
    pixel_t pixel_q[$];
    // The newest pixel of the current input byte, held back until its burst ends.
    pixel_t burst_tail;
    bit     burst_tail_ok;
    pixel_t got_px;
    pixel_t want_px;

    // Predicted decoder state.
    logic [15:0]               line_mem [MAX_PLANE_BYTES];
    bit                        run_open;
    logic [5:0]                run_cnt;
    logic [1:0]                plane;
    int                        col_offs;
    logic [IMAGE_HEIGHT_W-1:0] row_idx;
    bit                        done;

    // Shadow copies of the registers.
    logic [PLANE_BYTES_W-1:0]  reg_plane_bytes;
    logic [IMAGE_WIDTH_W-1:0]  reg_width;
    logic [IMAGE_HEIGHT_W-1:0] reg_height;

    int errors;
    int pixels;

    // Plane size as the decoder uses it, clamped to the line store depth.
    function automatic int plane_limit();
        int p;
        p = int'(reg_plane_bytes);
        if (p < 1) p = 1;
        if (p > MAX_PLANE_BYTES) p = MAX_PLANE_BYTES;
        return p;
    endfunction

    // A height of zero counts as a single row.
    function automatic int height_limit();
        return (reg_height == '0) ? 1 : int'(reg_height);
    endfunction

    // Place one decoded byte into the scan line and predict its pixel, if any.
    task automatic place_byte(input logic [7:0] b);
        int     pb;
        int     idx;
        int     lastcol;
        pixel_t px;
        pb  = plane_limit();
        idx = col_offs;
        if (!done) begin
            if (idx >= pb) idx = pb - 1;
            case (plane)
                PLANE_RED: begin
                    line_mem[idx] = {line_mem[idx][15:8], b};
                end
                PLANE_GREEN: begin
                    line_mem[idx] = {b, line_mem[idx][7:0]};
                end
                default: begin
                    if (idx < int'(reg_width)) begin
                        lastcol = ((int'(reg_width) < pb) ? int'(reg_width) : pb) - 1;
                        px.blue          = b;
                        px.green         = line_mem[idx][15:8];
                        px.red           = line_mem[idx][7:0];
                        px.column        = idx[COLUMN_W-1:0];
                        px.row           = row_idx;
                        px.last_of_burst = 1'b0;
                        px.last_of_image = (idx == lastcol) &&
                                           (int'(row_idx) + 1 == height_limit());
                        if (burst_tail_ok) pixel_q.push_back(burst_tail);
                        burst_tail    = px;
                        burst_tail_ok = 1'b1;
                    end
                end
            endcase

            // Advance through the plane, then to the next plane or row.
            if (idx + 1 >= pb) begin
                col_offs = 0;
                if (plane == PLANE_BLUE) begin
                    plane   = PLANE_RED;
                    row_idx = row_idx + 1'b1;
                    if (int'(row_idx) >= height_limit() || row_idx == '0) done = 1'b1;
                end else begin
                    plane = plane + 1'b1;
                end
            end else begin
                col_offs = idx + 1;
            end
        end
    endtask

    // Work out the pixels caused by one accepted input transaction.
    task automatic decode_byte(input logic [7:0] b, input logic sof);
        int k;
        if (sof) begin
            run_open = 1'b0;
            run_cnt  = '0;
            plane    = PLANE_RED;
            col_offs = 0;
            row_idx  = '0;
            done     = 1'b0;
        end
        if (run_open) begin
            for (k = 0; k < int'(run_cnt); k++) place_byte(b);
            run_open = 1'b0;
            run_cnt  = '0;
        end else if (b >= RUN_MARK) begin
            run_open = 1'b1;
            run_cnt  = 6'(b - RUN_MARK);
        end else begin
            place_byte(b);
        end
        if (burst_tail_ok) begin
            burst_tail.last_of_burst = 1'b1;
            pixel_q.push_back(burst_tail);
            burst_tail_ok = 1'b0;
        end
    endtask

    // Observe all three ports at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PLANE_BYTES; i++) line_mem[i] = '0;
            pixel_q.delete();
            burst_tail_ok   = 1'b0;
            run_open        = 1'b0;
            run_cnt         = '0;
            plane           = PLANE_RED;
            col_offs        = 0;
            row_idx         = '0;
            done            = 1'b0;
            reg_plane_bytes = RST_PLANE_BYTES;
            reg_width       = RST_IMAGE_WIDTH;
            reg_height      = RST_IMAGE_HEIGHT;
            errors          = 0;
            pixels          = 0;
        end else begin
            // Compare each pixel transaction with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got_px = {i_blue, i_green, i_red, i_column, i_row,
                          i_last_of_burst, i_last_of_image};
                pixels++;
                if (pixel_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected pixel blue %02h green %02h red %02h col %0d row %0d",
                                 $time, i_blue, i_green, i_red, i_column, i_row);
                    errors++;
                end else begin
                    want_px = pixel_q.pop_front();
                    if (got_px !== want_px) begin
                        if (errors < 10) begin
                            $display("%0t: pixel mismatch", $time);
                            $display("  expected b %02h g %02h r %02h col %0d row %0d lb %0b li %0b",
                                     want_px.blue, want_px.green, want_px.red, want_px.column,
                                     want_px.row, want_px.last_of_burst, want_px.last_of_image);
                            $display("  actual   b %02h g %02h r %02h col %0d row %0d lb %0b li %0b",
                                     got_px.blue, got_px.green, got_px.red, got_px.column,
                                     got_px.row, got_px.last_of_burst, got_px.last_of_image);
                        end
                        errors++;
                    end
                end
            end

            // Register writes take effect at once.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PLANE_BYTES:  reg_plane_bytes = i_cfg_data[PLANE_BYTES_W-1:0];
                    CFG_IMAGE_WIDTH:  reg_width       = i_cfg_data[IMAGE_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: reg_height      = i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) decode_byte(i_data_byte, i_start_of_image);
        end

        o_error_count = errors;
        o_pending     = pixel_q.size();
        o_pixel_count = pixels;
        o_image_done  = done;
    end

endmodule

// ===== tb/sv/pcx_rle_planar_decoder_tb.sv =====
`timescale 1ns / 100ps

module pcx_rle_planar_decoder_tb;
    import pcxrle_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int TIMEOUT_NS    = 10_000_000;

    // Register index that maps to no register.
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    logic                      i_clk;
    logic                      i_rst_n          = 1'b0;
    logic                      i_valid          = 1'b0;
    logic                      o_stall;
    logic [7:0]                i_data_byte      = '0;
    logic                      i_start_of_image = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [1:0]                i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data       = '0;
    logic                      o_valid;
    logic                      i_stall          = 1'b0;
    logic [7:0]                o_blue;
    logic [7:0]                o_green;
    logic [7:0]                o_red;
    logic [COLUMN_W-1:0]       o_column;
    logic [IMAGE_HEIGHT_W-1:0] o_row;
    logic                      o_last_of_burst;
    logic                      o_last_of_image;

    int   error_count;
    int   pending_pixels;
    int   pixel_count;
    logic image_done;

    int   bytes_sent   = 0;
    int   settings_run = 0;
    int   send_quiet   = 0;

    pcx_rle_planar_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_blue           (o_blue),
        .o_green          (o_green),
        .o_red            (o_red),
        .o_column         (o_column),
        .o_row            (o_row),
        .o_last_of_burst  (o_last_of_burst),
        .o_last_of_image  (o_last_of_image)
    );

    pcx_rle_planar_decoder_chk checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_blue           (o_blue),
        .i_green          (o_green),
        .i_red            (o_red),
        .i_column         (o_column),
        .i_row            (o_row),
        .i_last_of_burst  (o_last_of_burst),
        .i_last_of_image  (o_last_of_image),
        .o_error_count    (error_count),
        .o_pending        (pending_pixels),
        .o_pixel_count    (pixel_count),
        .o_image_done     (image_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Pixel receiver: stalls a random number of cycles before each transaction,
    // with occasional stretches of back-to-back acceptance.
    initial begin
        int gap;
        int quiet;
        quiet = 0;
        forever begin
            if (quiet > 0) begin
                gap = 0;
                quiet--;
            end else begin
                gap = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 40);
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Offer one byte and wait for its transaction. A byte that may start a new
    // image restarts it once the current image has ended, most of the time.
    // With hold_off set, the byte waits until every predicted pixel has come out.
    task automatic send_item(input logic [7:0] b, input logic sof,
                             input bit may_restart, input bit hold_off);
        int gap;
        if (send_quiet > 0) begin
            gap = 0;
            send_quiet--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) send_quiet = $urandom_range(10, 40);
        end
        if (hold_off && gap == 0) gap = 1;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            while (hold_off && pending_pixels != 0) @(negedge i_clk);
        end
        if (may_restart && image_done && $urandom_range(0, 9) != 0) sof = 1'b1;
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_start_of_image <= sof;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    // Let the decoder run dry: no sender, all pixels out, then a quiet margin
    // for placements that emit nothing.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers; the 11-bit ones sometimes carry junk above.
    task automatic configure(input int pb, input int width, input int height);
        logic [4:0] junk;
        settings_run++;
        junk = $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'd0;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PLANE_BYTES;
        i_cfg_data  <= {junk, 11'(pb)};
        junk = $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'd0;
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= {junk, 11'(width)};
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= 16'(height);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random stream for one register setting. Mostly well-formed literals and
    // run pairs; a few restarts and runs cut short by a new image.
    task automatic run_phase(input int n_items, input bit long_runs);
        int  i;
        int  r;
        bit  paused;
        bit  hold;
        logic [7:0] mark;
        paused = 1'b0;
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        i = 1;
        while (i < n_items) begin
            r    = $urandom_range(0, 99);
            hold = !paused && (i >= n_items / 2);
            if (hold) paused = 1'b1;
            if (r < 4) begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, hold);
                i++;
            end else if (r < 7) begin
                send_item(RUN_MARK + 8'($urandom_range(0, 63)), 1'b0, 1'b1, hold);
                send_item(8'($urandom_range(0, 191)), 1'b1, 1'b0, 1'b0);
                i += 2;
            end else if (r < (long_runs ? 92 : 45)) begin
                mark = RUN_MARK + 8'(long_runs ? $urandom_range(48, 63) : $urandom_range(0, 63));
                send_item(mark, 1'b0, 1'b1, hold);
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                i += 2;
            end else begin
                send_item(8'($urandom_range(0, 191)), 1'b0, 1'b1, hold);
                i++;
            end
        end
        drain();
    endtask

    initial begin
        int pb;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A write to the spare index must change nothing.
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPARE_INDEX;
        i_cfg_data  <= 16'($urandom_range(0, 65535));

        // Directed part: four bytes per plane, three visible columns, two rows.
        configure(4, 3, 2);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'd191, 1'b0, 1'b0, 1'b0);
        // A zero-length run swallows the byte after it.
        send_item(RUN_MARK, 1'b0, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        // Run data at or above the marker value is repeated, not decoded.
        send_item(RUN_MARK + 8'd6, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(RUN_MARK + 8'd1, 1'b0, 1'b0, 1'b0);
        send_item(RUN_MARK, 1'b0, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0, 1'b0);
        // Two placements: the last visible column and one padding column.
        send_item(RUN_MARK + 8'd2, 1'b0, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0, 1'b0);
        // The longest run finishes the image and overflows past the last row.
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0, 1'b0);
        // Bytes after the last row are dropped, runs included.
        send_item(8'h12, 1'b0, 1'b0, 1'b0);
        send_item(RUN_MARK + 8'd5, 1'b0, 1'b0, 1'b0);
        send_item(8'h34, 1'b0, 1'b0, 1'b0);
        // A new image cancels a pending run.
        send_item(RUN_MARK + 8'd3, 1'b0, 1'b0, 1'b0);
        send_item(8'h10, 1'b1, 1'b0, 1'b0);
        // A new image can begin with a run marker.
        send_item(RUN_MARK + 8'd12, 1'b1, 1'b0, 1'b0);
        send_item(8'h77, 1'b0, 1'b0, 1'b0);
        send_item(8'h2C, 1'b0, 1'b0, 1'b0);
        drain();

        // Register extremes, then random small settings.
        configure(1, 1, 1);
        run_phase(15, 1'b0);
        configure(0, 2047, 0);
        run_phase(15, 1'b0);
        configure(5, 0, 3);
        run_phase(15, 1'b0);
        configure(1024, 1024, 1);
        run_phase(110, 1'b1);
        configure(2047, 2047, 65535);
        run_phase(15, 1'b1);
        repeat (4) begin
            pb = $urandom_range(1, 8);
            configure(pb, $urandom_range(0, pb + 1), $urandom_range(1, 3));
            run_phase(15, 1'b0);
        end

        $display("Sent %0d compressed bytes under %0d register settings; %0d pixels compared.",
                 bytes_sent, settings_run, pixel_count);
        $display("Settings covered one-byte planes, saturated sizes, zero width and height.");
        if (error_count == 0 && pending_pixels == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
